// ===== rtl/prp_pkg.sv =====
package prp_pkg;

  // Field and register widths fixed by the interface
  localparam int FRAME_W    = 4;
  localparam int LFSR_W     = 16;
  localparam int MOD_CNT_W  = 4;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 16;

  // Replacement policy codes
  localparam logic [1:0] POL_RANDOM = 2'd0;
  localparam logic [1:0] POL_FIFO   = 2'd1;
  localparam logic [1:0] POL_LRU    = 2'd2;
  localparam logic [1:0] POL_CLOCK  = 2'd3;

  // Operation codes
  localparam logic OP_TOUCH  = 1'b0;
  localparam logic OP_VICTIM = 1'b1;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_POLICY = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_SEED   = 1'b1;

  // Random generator constants
  localparam logic [LFSR_W-1:0] SEED_RESET = 16'hACE1;
  localparam logic [LFSR_W-1:0] LFSR_TAPS  = 16'hB400;
  // Remainder steps: quotient first, then remainder
  localparam logic [MOD_CNT_W-1:0] MOD_LAST_CNT = 4'd1;

  // Commands from controller to datapath
  typedef struct packed {
    logic accept;
    logic ref_set;
    logic rand_start;
    logic mod_iter;
    logic fifo_take;
    logic lru_empty;
    logic sweep;
    logic walk;
    logic lru_final;
  } cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic [1:0] policy;
    logic       frame_ok;
    logic       lru_none;
    logic       mod_last;
    logic       ref_hit;
    logic       walk_done;
    logic       victim_op;
  } status_t;

endpackage

// ===== rtl/page_replacement_policy.sv =====
// Channel   Handshake               Payload
// input     start, busy             in_operation, in_frame
// result    out_strobe              out_victim_frame, out_empty_flag
// config    cfg_we                  cfg_index, cfg_data
//
// A touch under random, FIFO or clock is done as it is accepted; under LRU it
// walks the recency memory through its read port.
// A victim goes straight to the result under FIFO or an empty LRU; under random
// it takes a reciprocal multiply, then the remainder; under LRU it walks the
// recency memory; under clock it sweeps from the hand, one frame a cycle.
// The result strobe is high for one cycle; the receiver cannot stall it.
// Reset is synchronous; no clearing pass is needed after it.
module page_replacement_policy #(
  parameter int FRAMES = 16
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  output logic                           busy,
  input  logic                           in_operation,
  input  logic [prp_pkg::FRAME_W-1:0]    in_frame,
  output logic                           out_strobe,
  output logic [prp_pkg::FRAME_W-1:0]    out_victim_frame,
  output logic                           out_empty_flag,
  input  logic                           cfg_we,
  input  logic [prp_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [prp_pkg::CFG_DATA_W-1:0] cfg_data
);

  prp_pkg::cmd_t    cmd;
  prp_pkg::status_t status;

  prp_ctrl u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .in_operation (in_operation),
    .status       (status),
    .cmd          (cmd),
    .busy         (busy),
    .out_strobe   (out_strobe)
  );

  prp_datapath #(
    .FRAMES (FRAMES)
  ) u_datapath (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_operation (in_operation),
    .in_frame     (in_frame),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .cmd          (cmd),
    .status       (status),
    .res_frame    (out_victim_frame),
    .res_empty    (out_empty_flag)
  );

endmodule

// ===== rtl/prp_datapath.sv =====
module prp_datapath #(
  parameter int FRAMES = 16
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_operation,
  input  logic [prp_pkg::FRAME_W-1:0]      in_frame,
  input  logic                             cfg_we,
  input  logic [prp_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [prp_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  prp_pkg::cmd_t                    cmd,
  output prp_pkg::status_t                 status,
  output logic [prp_pkg::FRAME_W-1:0]      res_frame,
  output logic                             res_empty
);

  localparam int FW = $clog2(FRAMES);
  localparam int CW = $clog2(FRAMES + 1);
  localparam int XW = FW + prp_pkg::FRAME_W;
  localparam int PW = prp_pkg::LFSR_W + 32;
  localparam logic [31:0] RECIP = 32'(((64'd1 << 32) + 64'(FRAMES - 1)) / 64'(FRAMES));

  // Configuration and policy state
  logic [1:0]                   policy_r;
  logic [prp_pkg::LFSR_W-1:0]   lfsr_r;
  logic [prp_pkg::LFSR_W-1:0]   lfsr_nxt;
  logic [FW-1:0]                fifo_ptr_r;
  logic [FW-1:0]                hand_r;
  logic                         ref_r [FRAMES];
  logic [CW-1:0]                count_r;

  // Per-item working registers
  logic                         op_r;
  logic [FW-1:0]                key_r;
  logic [CW-1:0]                rd_idx_r;
  logic                         pend_r;
  logic [FW-1:0]                pend_idx_r;
  logic                         found_r;
  logic [FW-1:0]                sweep_r;
  logic [FW-1:0]                sweep_nxt;
  logic [prp_pkg::LFSR_W-1:0]   mod_sr_r;
  logic [prp_pkg::LFSR_W-1:0]   quot_r;
  logic [PW-1:0]                recip_prod;
  logic [prp_pkg::LFSR_W-1:0]   quot_mul;
  logic [prp_pkg::LFSR_W-1:0]   rem_full;
  logic [prp_pkg::MOD_CNT_W-1:0] mod_cnt_r;
  logic [FW-1:0]                res_frame_r;
  logic                         res_empty_r;

  // Recency order memory
  logic [FW-1:0]                mem [FRAMES];
  logic [FW-1:0]                rd_data_r;
  logic                         mem_we;
  logic [FW-1:0]                mem_waddr;
  logic [FW-1:0]                mem_wdata;

  logic [XW-1:0]                frame_ext;
  logic [FW-1:0]                frame_idx;
  logic                         frame_ok;
  logic                         issue;
  logic                         hit;
  logic [CW-1:0]                count_m1;
  logic [XW-1:0]                res_ext;

  // Range check of the named frame
  assign frame_ext = {{FW{1'b0}}, in_frame};
  assign frame_ok  = frame_ext < XW'(FRAMES);
  assign frame_idx = frame_ext[FW-1:0];

  // Galois step of the random generator
  assign lfsr_nxt = (lfsr_r >> 1) ^ (lfsr_r[0] ? prp_pkg::LFSR_TAPS : '0);

  // Remainder by FRAMES: scaled reciprocal gives the exact quotient for 16-bit values
  assign recip_prod = PW'(mod_sr_r) * PW'(RECIP);
  assign quot_mul   = quot_r * prp_pkg::LFSR_W'(FRAMES);
  assign rem_full   = mod_sr_r - quot_mul;

  // Wrap the clock sweep index
  assign sweep_nxt = (sweep_r == FW'(FRAMES - 1)) ? '0 : sweep_r + 1'b1;

  // Walk bookkeeping
  assign issue    = rd_idx_r != count_r;
  assign hit      = (op_r == prp_pkg::OP_VICTIM) ? (pend_idx_r == '0)
                                                 : (rd_data_r == key_r);
  assign count_m1 = count_r - 1'b1;

  // Select the memory write
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = pend_idx_r - 1'b1;
    mem_wdata = rd_data_r;
    if (cmd.walk && pend_r && found_r) begin
      mem_we = 1'b1;
    end else if (cmd.lru_final) begin
      mem_wdata = key_r;
      if (found_r) begin
        mem_we    = 1'b1;
        mem_waddr = count_m1[FW-1:0];
      end else if (count_r != CW'(FRAMES)) begin
        mem_we    = 1'b1;
        mem_waddr = count_r[FW-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rd_data_r <= mem[rd_idx_r[FW-1:0]];
  end

  // Policy state and configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      policy_r   <= prp_pkg::POL_FIFO;
      lfsr_r     <= prp_pkg::SEED_RESET;
      fifo_ptr_r <= '0;
      hand_r     <= '0;
      count_r    <= '0;
      pend_r     <= 1'b0;
      found_r    <= 1'b0;
      for (int i = 0; i < FRAMES; i++) begin
        ref_r[i] <= 1'b0;
      end
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          prp_pkg::CFG_POLICY: policy_r <= cfg_data[1:0];
          prp_pkg::CFG_SEED:   lfsr_r   <= (cfg_data == '0) ? prp_pkg::SEED_RESET
                                                            : cfg_data;
          default: ;
        endcase
      end
      if (cmd.accept) begin
        pend_r  <= 1'b0;
        found_r <= 1'b0;
      end
      if (cmd.ref_set) begin
        ref_r[frame_idx] <= 1'b1;
      end
      if (cmd.rand_start) begin
        lfsr_r <= lfsr_nxt;
      end
      if (cmd.fifo_take) begin
        fifo_ptr_r <= (fifo_ptr_r == FW'(FRAMES - 1)) ? '0 : fifo_ptr_r + 1'b1;
      end
      // Clear set bits, claim the first clear one
      if (cmd.sweep) begin
        if (ref_r[sweep_r]) begin
          ref_r[sweep_r] <= 1'b0;
        end else begin
          ref_r[sweep_r] <= 1'b1;
          hand_r         <= sweep_r;
        end
      end
      if (cmd.walk) begin
        pend_r <= issue;
        if (pend_r) begin
          found_r <= found_r | hit;
        end
      end
      if (cmd.lru_final && !found_r && count_r != CW'(FRAMES)) begin
        count_r <= count_r + 1'b1;
      end
    end
  end

  // Working registers and result
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      op_r     <= in_operation;
      key_r    <= frame_idx;
      rd_idx_r <= '0;
      sweep_r  <= hand_r;
    end
    if (cmd.rand_start) begin
      mod_sr_r  <= lfsr_nxt;
      mod_cnt_r <= '0;
    end
    // Register the quotient, then take the remainder
    if (cmd.mod_iter) begin
      mod_cnt_r <= mod_cnt_r + 1'b1;
      if (mod_cnt_r == prp_pkg::MOD_LAST_CNT) begin
        res_frame_r <= rem_full[FW-1:0];
        res_empty_r <= 1'b0;
      end else begin
        quot_r <= recip_prod[PW-1:32];
      end
    end
    if (cmd.fifo_take) begin
      res_frame_r <= fifo_ptr_r;
      res_empty_r <= 1'b0;
    end
    if (cmd.lru_empty) begin
      res_frame_r <= '0;
      res_empty_r <= 1'b1;
    end
    if (cmd.sweep) begin
      if (ref_r[sweep_r]) begin
        sweep_r <= sweep_nxt;
      end else begin
        res_frame_r <= sweep_r;
        res_empty_r <= 1'b0;
      end
    end
    // Stream entries through the read port, shift down behind the match
    if (cmd.walk) begin
      if (issue) begin
        rd_idx_r   <= rd_idx_r + 1'b1;
        pend_idx_r <= rd_idx_r[FW-1:0];
      end
      if (pend_r && op_r == prp_pkg::OP_VICTIM && pend_idx_r == '0) begin
        key_r <= rd_data_r;
      end
    end
    if (cmd.lru_final) begin
      res_frame_r <= key_r;
      res_empty_r <= 1'b0;
    end
  end

  assign res_ext   = {{prp_pkg::FRAME_W{1'b0}}, res_frame_r};
  assign res_frame = res_ext[prp_pkg::FRAME_W-1:0];
  assign res_empty = res_empty_r;

  assign status.policy    = policy_r;
  assign status.frame_ok  = frame_ok;
  assign status.lru_none  = count_r == '0;
  assign status.mod_last  = mod_cnt_r == prp_pkg::MOD_LAST_CNT;
  assign status.ref_hit   = ref_r[sweep_r];
  assign status.walk_done = !issue && !pend_r;
  assign status.victim_op = op_r == prp_pkg::OP_VICTIM;

endmodule

// ===== rtl/prp_ctrl.sv =====
module prp_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic             in_operation,
  input  prp_pkg::status_t status,
  output prp_pkg::cmd_t    cmd,
  output logic             busy,
  output logic             out_strobe
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RAND,
    ST_CLOCK,
    ST_LRU_WALK,
    ST_LRU_LAST,
    ST_EMIT
  } state_t;

  state_t state_r;
  state_t state_nxt;
  logic   busy_r;
  logic   out_strobe_r;

  // Decode next state and datapath commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      ST_IDLE: begin
        if (start) begin
          cmd.accept = 1'b1;
          if (in_operation == prp_pkg::OP_TOUCH) begin
            if (status.frame_ok) begin
              if (status.policy == prp_pkg::POL_LRU) begin
                state_nxt = ST_LRU_WALK;
              end else if (status.policy == prp_pkg::POL_CLOCK) begin
                cmd.ref_set = 1'b1;
              end
            end
          end else begin
            case (status.policy)
              prp_pkg::POL_RANDOM: begin
                cmd.rand_start = 1'b1;
                state_nxt      = ST_RAND;
              end
              prp_pkg::POL_FIFO: begin
                cmd.fifo_take = 1'b1;
                state_nxt     = ST_EMIT;
              end
              prp_pkg::POL_LRU: begin
                if (status.lru_none) begin
                  cmd.lru_empty = 1'b1;
                  state_nxt     = ST_EMIT;
                end else begin
                  state_nxt = ST_LRU_WALK;
                end
              end
              default: begin
                state_nxt = ST_CLOCK;
              end
            endcase
          end
        end
      end
      ST_RAND: begin
        cmd.mod_iter = 1'b1;
        if (status.mod_last) begin
          state_nxt = ST_EMIT;
        end
      end
      ST_CLOCK: begin
        cmd.sweep = 1'b1;
        if (!status.ref_hit) begin
          state_nxt = ST_EMIT;
        end
      end
      ST_LRU_WALK: begin
        cmd.walk = 1'b1;
        if (status.walk_done) begin
          state_nxt = ST_LRU_LAST;
        end
      end
      ST_LRU_LAST: begin
        cmd.lru_final = 1'b1;
        state_nxt     = status.victim_op ? ST_EMIT : ST_IDLE;
      end
      ST_EMIT: begin
        state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Hold state and registered handshake outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      busy_r       <= 1'b0;
      out_strobe_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      busy_r       <= state_nxt != ST_IDLE;
      out_strobe_r <= state_nxt == ST_EMIT;
    end
  end

  assign busy       = busy_r;
  assign out_strobe = out_strobe_r;

endmodule

// ===== rtl/prp_checker.sv =====
module prp_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        start,
  input logic                        busy,
  input logic                        in_operation,
  input logic                        out_strobe,
  input logic [prp_pkg::FRAME_W-1:0] out_victim_frame,
  input logic                        out_empty_flag
);

  // Leave reset idle with no result
  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !busy && !out_strobe)
    else $error("busy or strobe after reset");

  // A result is a single-cycle transfer
  a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |=> !out_strobe)
    else $error("result strobe held two cycles");

  // No result while the block shows idle
  a_strobe_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> busy)
    else $error("result strobe while idle");

  // A victim request always occupies the block
  a_victim_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_operation == prp_pkg::OP_VICTIM) |=> busy)
    else $error("victim request did not raise busy");

  // An empty answer names frame zero
  a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_empty_flag) |-> out_victim_frame == '0)
    else $error("empty result with nonzero frame");

endmodule

bind page_replacement_policy prp_checker u_prp_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .start            (start),
  .busy             (busy),
  .in_operation     (in_operation),
  .out_strobe       (out_strobe),
  .out_victim_frame (out_victim_frame),
  .out_empty_flag   (out_empty_flag)
);

// ===== verif/tb.sv =====
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import prp_pkg::*;

  localparam int NUM_FRAMES    = 16;
  localparam int SETTLE_CYCLES = 40;
  localparam int STALL_LIMIT   = 4000;
  localparam int PHASES        = 12;
  localparam int PHASE_ITEMS   = 48;

  typedef struct {
    logic               op;
    logic [FRAME_W-1:0] frame;
  } page_req_t;

  typedef struct {
    logic [FRAME_W-1:0] victim;
    logic               empty;
  } victim_t;

  logic                  clk          = 1'b0;
  logic                  rst_n        = 1'b0;
  logic                  start        = 1'b0;
  logic                  in_operation = 1'b0;
  logic [FRAME_W-1:0]    in_frame     = '0;
  logic                  cfg_we       = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index    = '0;
  logic [CFG_DATA_W-1:0] cfg_data     = '0;
  logic                  busy;
  logic                  out_strobe;
  logic [FRAME_W-1:0]    out_victim_frame;
  logic                  out_empty_flag;

  page_req_t req_q[$];
  victim_t   victim_exp_q[$];
  int        errors       = 0;
  int        idle_pct     = 0;
  int        gap_left     = 0;
  int        stall_cycles = 0;

  // Predictor state, one copy per policy
  logic [1:0]            m_policy   = POL_FIFO;
  logic [LFSR_W-1:0]     m_lfsr     = SEED_RESET;
  logic [FRAME_W-1:0]    m_fifo_ptr = '0;
  logic [FRAME_W-1:0]    m_hand     = '0;
  logic [NUM_FRAMES-1:0] m_ref      = '0;
  logic [FRAME_W-1:0]    m_order [NUM_FRAMES];
  int                    m_tracked  = 0;

  page_replacement_policy #(.FRAMES(NUM_FRAMES)) i_dut (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Move a frame to the most recent end of the recency order, add it if new
  function automatic void lru_touch(logic [FRAME_W-1:0] f);
    int pos;
    pos = m_tracked;
    for (int i = 0; i < m_tracked; i++)
      if (pos == m_tracked && m_order[i] == f) pos = i;
    if (pos < m_tracked) begin
      for (int i = pos; i + 1 < m_tracked; i++) m_order[i] = m_order[i+1];
      m_order[m_tracked-1] = f;
    end else if (m_tracked < NUM_FRAMES) begin
      m_order[m_tracked] = f;
      m_tracked++;
    end
  endfunction

  // Sweep from the hand; with every bit set, wrap back to the hand frame
  function automatic logic [FRAME_W-1:0] clock_pick();
    logic [FRAME_W-1:0] idx;
    for (int i = 0; i < NUM_FRAMES; i++) begin
      idx = m_hand + FRAME_W'(i);
      if (m_ref[idx]) begin
        m_ref[idx] = 1'b0;
      end else begin
        m_ref[idx] = 1'b1;
        m_hand = idx;
        return idx;
      end
    end
    m_ref[m_hand] = 1'b1;
    return m_hand;
  endfunction

  function automatic victim_t predict_victim();
    victim_t r;
    r.victim = '0;
    r.empty  = 1'b0;
    case (m_policy)
      POL_RANDOM: begin
        m_lfsr   = m_lfsr[0] ? ((m_lfsr >> 1) ^ LFSR_TAPS) : (m_lfsr >> 1);
        r.victim = m_lfsr[FRAME_W-1:0];
      end
      POL_FIFO: begin
        r.victim   = m_fifo_ptr;
        m_fifo_ptr = m_fifo_ptr + 1'b1;
      end
      POL_LRU: begin
        if (m_tracked == 0) begin
          r.empty = 1'b1;
        end else begin
          r.victim = m_order[0];
          lru_touch(r.victim);
        end
      end
      default: r.victim = clock_pick();
    endcase
    return r;
  endfunction

  function automatic void apply_touch(logic [FRAME_W-1:0] f);
    if (m_policy == POL_LRU) lru_touch(f);
    else if (m_policy == POL_CLOCK) m_ref[f] = 1'b1;
  endfunction

  // Driver: present the oldest pending item, predict on each transfer
  always @(posedge clk) begin
    page_req_t req;
    if (!rst_n) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        req = req_q.pop_front();
        if (req.op == OP_VICTIM) victim_exp_q.push_back(predict_victim());
        else apply_touch(req.frame);
        if ($urandom_range(99) < idle_pct) gap_left = $urandom_range(13, 1);
      end
      if (!(start && busy)) begin
        if (gap_left > 0) begin
          start <= 1'b0;
          gap_left--;
        end else if (req_q.size() > 0) begin
          start        <= 1'b1;
          in_operation <= req_q[0].op;
          in_frame     <= req_q[0].frame;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // Monitor: compare each result with the oldest expectation
  always @(posedge clk) begin
    victim_t exp_v;
    if (rst_n && out_strobe) begin
      if (victim_exp_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected result, expected none, actual victim_frame %0d empty_flag %0b",
                 $time, out_victim_frame, out_empty_flag);
      end else begin
        exp_v = victim_exp_q.pop_front();
        if (out_victim_frame !== exp_v.victim) begin
          errors++;
          $display("%0t: victim_frame expected %0d actual %0d",
                   $time, exp_v.victim, out_victim_frame);
        end
        if (out_empty_flag !== exp_v.empty) begin
          errors++;
          $display("%0t: empty_flag expected %0b actual %0b",
                   $time, exp_v.empty, out_empty_flag);
        end
      end
    end
  end

  // Watchdog: end the run when no transfer happens for too long
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_strobe) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  task automatic add_req(logic op, logic [FRAME_W-1:0] f);
    page_req_t r;
    r.op    = op;
    r.frame = f;
    req_q.push_back(r);
  endtask

  // Wait until every item is taken, every result is in and the block is quiet
  task automatic wait_idle();
    do @(negedge clk);
    while (req_q.size() != 0 || victim_exp_q.size() != 0 || start);
    repeat (SETTLE_CYCLES) @(negedge clk);
    while (busy) @(negedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] d);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= d;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_POLICY) begin
      m_policy = d[1:0];
    end else begin
      // a zero seed falls back to the reset seed
      m_lfsr = (d == '0) ? SEED_RESET : d;
    end
    @(negedge clk);
  endtask

  initial begin
    logic [1:0]            pol;
    logic [CFG_DATA_W-1:0] seed;
    int                    victim_pct;
    int                    taken;
    logic                  op;

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed: FIFO after reset, touch has no effect
    idle_pct = 30;
    add_req(OP_VICTIM, '0);
    add_req(OP_TOUCH, 4'd5);
    add_req(OP_VICTIM, '1);
    wait_idle();

    // Directed: random policy with a zero seed
    write_reg(CFG_POLICY, CFG_DATA_W'(POL_RANDOM));
    write_reg(CFG_SEED, '0);
    add_req(OP_VICTIM, '0);
    add_req(OP_VICTIM, '1);
    wait_idle();

    // Directed: empty LRU, then reorder on repeated touch
    write_reg(CFG_POLICY, CFG_DATA_W'(POL_LRU));
    add_req(OP_VICTIM, '0);
    add_req(OP_TOUCH, 4'd0);
    add_req(OP_TOUCH, 4'd15);
    add_req(OP_TOUCH, 4'd0);
    add_req(OP_VICTIM, '0);
    wait_idle();

    // Directed: clock, pick the hand frame, then the all-bits-set wrap
    write_reg(CFG_POLICY, CFG_DATA_W'(POL_CLOCK));
    for (int f = 1; f < NUM_FRAMES; f++) add_req(OP_TOUCH, FRAME_W'(f));
    add_req(OP_VICTIM, '0);
    add_req(OP_VICTIM, '0);
    wait_idle();

    // Random phases, each under its own setting
    for (int p = 0; p < PHASES; p++) begin
      pol = (p < 4) ? 2'(p) : 2'($urandom_range(3));
      write_reg(CFG_POLICY, (CFG_DATA_W'($urandom()) & ~CFG_DATA_W'(3)) | CFG_DATA_W'(pol));
      if (p == 0) begin
        write_reg(CFG_SEED, CFG_DATA_W'(1));
      end else if (p == 1) begin
        write_reg(CFG_SEED, '1);
      end else if ($urandom_range(3) == 0) begin
        seed = ($urandom_range(7) == 0) ? '0 : CFG_DATA_W'($urandom_range(65535, 1));
        write_reg(CFG_SEED, seed);
      end
      case ($urandom_range(2))
        0:       idle_pct = 0;
        1:       idle_pct = 25;
        default: idle_pct = 60;
      endcase
      if (p >= PHASES - 2) idle_pct = 0;
      case (pol)
        POL_LRU:   victim_pct = 35;
        POL_CLOCK: victim_pct = 45;
        default:   victim_pct = 85;
      endcase
      taken = 0;
      while (taken < PHASE_ITEMS) begin
        op = ($urandom_range(99) < victim_pct) ? OP_VICTIM : OP_TOUCH;
        add_req(op, FRAME_W'($urandom_range(NUM_FRAMES - 1)));
        // touches under random and FIFO are ignored by the block
        if (op == OP_VICTIM || pol == POL_LRU || pol == POL_CLOCK) taken++;
      end
      wait_idle();
    end

    if (errors == 0 && victim_exp_q.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/prp_pkg.sv
rtl/prp_datapath.sv
rtl/prp_ctrl.sv
rtl/page_replacement_policy.sv
rtl/prp_checker.sv
verif/tb.sv
